// File: rtl/swm_pkg.sv
// shared constants and types of the sliding window median core
package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int DATA_W     = 32;
  localparam int OUT_W      = DATA_W + 1;
  localparam int WS_W       = 7;

  localparam logic [WS_W-1:0] WS_RESET = WS_W'(3);

  // broadcast from the top level to every cell of the sorted row
  typedef struct packed {
    logic              en;
    logic              full;
    logic              up;
    logic [DATA_W-1:0] sample;
    logic [DATA_W-1:0] old;
  } swm_ctl_t;

  // what a cell shows to its neighbors
  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              le;
    logic              ge_old;
  } swm_nbr_t;

endpackage

// File: rtl/swm_ram.sv
// generic single write port ram with registered read
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/swm_cell.sv
// one slot of the sorted row: evicts, inserts and shifts with its neighbors
module swm_cell import swm_pkg::*; (
  input  logic     clk_i,
  input  swm_ctl_t ctl_i,
  input  logic     in_win_i,
  input  swm_nbr_t left_i,
  input  swm_nbr_t right_i,
  output swm_nbr_t nbr_o
);

  logic [DATA_W-1:0] val_q, val_d;
  logic              le;
  logic              ge_old;

  // le: slot holds a value not above the new sample
  // ge_old: slot is at or past the evicted entry (or outside the window)
  assign le     = in_win_i && ($signed(val_q) <= $signed(ctl_i.sample));
  assign ge_old = !in_win_i || (ctl_i.full && ($signed(val_q) >= $signed(ctl_i.old)));

  always_comb begin
    val_d = val_q;
    if (ctl_i.up) begin
      // new sample not below evicted one: gap closes from the right
      if (!ge_old) begin
        val_d = val_q;
      end else if (right_i.le) begin
        val_d = right_i.val;
      end else if (le) begin
        val_d = ctl_i.sample;
      end
    end else begin
      // new sample below evicted one (or filling): entries move right
      if (le) begin
        val_d = val_q;
      end else if (left_i.le) begin
        val_d = ctl_i.sample;
      end else if (!left_i.ge_old) begin
        val_d = left_i.val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      val_q <= val_d;
    end
  end

  assign nbr_o = '{val: val_q, le: le, ge_old: ge_old};

endmodule

// File: rtl/sliding_window_median_core.sv
// top level of the sliding window median core
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------
//  input   | in_valid_i / in_stall_o | sample_i (32 bit signed)
//  output  | out_valid_o / out_stall_i | median_twice_o (33 bit signed)
//  config  | cfg_we_i               | cfg_wdata_i (window_size, 7 bit)
//
// one sample per cycle while in_stall_o is low; a result passes from the sorted row update at
// the transfer through the middle pair capture to the sum into the output register
// in_stall_o rises only when a result waits in the row while both later stages are full
// and the output is stalled
// reset: window_size 3, window empty; sample storage needs no clearing
// a config write empties the window and the next window_size - 1 samples give no result
module sliding_window_median_core import swm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [WS_W-1:0]          cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [OUT_W-1:0]  median_twice_o
);

  // window size register and effective window
  logic [WS_W-1:0]  ws_q;
  logic [CNT_W-1:0] eff_w;

  always_comb begin
    if (ws_q == '0) begin
      eff_w = CNT_W'(1);
    end else if (CNT_W'(ws_q) > CNT_W'(WINDOW_MAX)) begin
      eff_w = CNT_W'(WINDOW_MAX);
    end else begin
      eff_w = CNT_W'(ws_q);
    end
  end

  // fill count and oldest pointer
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic             full;
  logic             emit;
  logic             in_acc;

  assign full   = (fill_q == eff_w);
  assign emit   = full || ((fill_q + CNT_W'(1)) == eff_w);
  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    fill_d = fill_q;
    ptr_d  = ptr_q;
    if (cfg_we_i) begin
      fill_d = '0;
      ptr_d  = '0;
    end else if (in_acc) begin
      if (!full) begin
        fill_d = fill_q + CNT_W'(1);
      end else if ((CNT_W'(ptr_q) + CNT_W'(1)) == eff_w) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + IDX_W'(1);
      end
    end
  end

  // history ring: read address tracks the next oldest pointer so the evicted
  // sample is ready at the next transfer
  logic [IDX_W-1:0]  ring_waddr;
  logic [DATA_W-1:0] ring_rdata;
  logic              byp_q;
  logic [DATA_W-1:0] byp_val_q;
  logic [DATA_W-1:0] old_val;

  assign ring_waddr = full ? ptr_q : fill_q[IDX_W-1:0];

  swm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (ring_waddr),
    .wdata_i (sample_i),
    .raddr_i (ptr_d),
    .rdata_o (ring_rdata)
  );

  // write and read of the same slot in one cycle (window of one, first sample)
  always_ff @(posedge clk_i) begin
    byp_val_q <= sample_i;
  end

  assign old_val = byp_q ? byp_val_q : ring_rdata;

  // sorted row of cells
  swm_ctl_t          ctl;
  swm_nbr_t          nbr [WINDOW_MAX];
  logic [DATA_W-1:0] cell_val [WINDOW_MAX];

  assign ctl = '{
    en:     in_acc,
    full:   full,
    up:     full && ($signed(sample_i) >= $signed(old_val)),
    sample: sample_i,
    old:    old_val
  };

  localparam swm_nbr_t LEFT_EDGE  = '{val: '0, le: 1'b1, ge_old: 1'b1};
  localparam swm_nbr_t RIGHT_EDGE = '{val: '0, le: 1'b0, ge_old: 1'b1};

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_nbr_t left_n, right_n;
    logic     in_win;

    assign in_win = (CNT_W'(i) < fill_q);

    if (i == 0) begin : g_first
      assign left_n = LEFT_EDGE;
    end else begin : g_mid_l
      assign left_n = nbr[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_n = RIGHT_EDGE;
    end else begin : g_mid_r
      assign right_n = nbr[i+1];
    end

    swm_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .in_win_i (in_win),
      .left_i   (left_n),
      .right_i  (right_n),
      .nbr_o    (nbr[i])
    );

    assign cell_val[i] = nbr[i].val;
  end

  // result pipeline: pending flag, middle pair, output register
  logic              pend_q;
  logic              mid_valid_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] lo_q, hi_q;
  logic [OUT_W-1:0]  out_q;
  logic [IDX_W-1:0]  lo_idx, hi_idx;
  logic              out_free, mid_move, mid_free, pend_move;

  assign lo_idx = IDX_W'((eff_w - CNT_W'(1)) >> 1);
  assign hi_idx = eff_w[IDX_W:1];

  assign out_free  = !out_valid_q || !out_stall_i;
  assign mid_move  = mid_valid_q && out_free;
  assign mid_free  = !mid_valid_q || mid_move;
  assign pend_move = pend_q && mid_free;
  assign in_stall_o = pend_q && !mid_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= WS_RESET;
      fill_q      <= '0;
      ptr_q       <= '0;
      byp_q       <= 1'b0;
      pend_q      <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ws_q <= cfg_wdata_i;
      end
      fill_q <= fill_d;
      ptr_q  <= ptr_d;
      byp_q  <= in_acc && (ring_waddr == ptr_d);

      if (in_acc && emit) begin
        pend_q <= 1'b1;
      end else if (pend_move) begin
        pend_q <= 1'b0;
      end

      if (pend_move) begin
        mid_valid_q <= 1'b1;
      end else if (mid_move) begin
        mid_valid_q <= 1'b0;
      end

      if (mid_move) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      lo_q <= cell_val[lo_idx];
      hi_q <= cell_val[hi_idx];
    end
    if (mid_move) begin
      out_q <= {lo_q[DATA_W-1], lo_q} + {hi_q[DATA_W-1], hi_q};
    end
  end

  assign out_valid_o    = out_valid_q;
  assign median_twice_o = out_q;

  // checks
  logic [WINDOW_MAX-2:0] order_bad;

  for (genvar i = 0; i < WINDOW_MAX - 1; i++) begin : g_order
    assign order_bad[i] = (CNT_W'(i + 1) < fill_q) &&
                          ($signed(cell_val[i]) > $signed(cell_val[i+1]));
  end

  a_fill_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= eff_w)
    else $error("fill count beyond window size");

  a_ptr_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (CNT_W'(ptr_q) < eff_w))
    else $error("oldest pointer outside window");

  a_row_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    order_bad == '0)
    else $error("sorted row out of order");

endmodule
